@@ hdl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers, clocked on clock.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DTN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define DTN_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/dtn_pkg.sv @@
// -----------------------------------------------------------------------------
// dtn_pkg
// Types, codes and the unit table of the delay to tick normalizer.
// -----------------------------------------------------------------------------
package dtn_pkg;

   localparam int WORD_W     = 64;
   localparam int TIME_WIDTH = 64;
   localparam int CNT_W      = $clog2(WORD_W);
   localparam logic [WORD_W-1:0] TIME_LIMIT = {WORD_W{1'b1}} >> (WORD_W - TIME_WIDTH);
   localparam logic [WORD_W-1:0] TICK_RESET = 64'd1000000;

   localparam logic [3:0] UNIT_NONE = 4'd0;
   localparam logic [3:0] UNIT_HR   = 4'd8;

   typedef enum logic [3:0] {
      ST_OK            = 4'd0,
      ST_UNITLESS_FRAC = 4'd1,
      ST_INVALID       = 4'd2,
      ST_TIME_OVF      = 4'd3,
      ST_PREC_RANGE    = 4'd4,
      ST_ZERO_DEN      = 4'd5,
      ST_ROUND_OVF     = 4'd6,
      ST_INEXACT       = 4'd7,
      ST_PREC_NOT_MULT = 4'd8,
      ST_TICK_OVF      = 4'd9
   } status_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_GCD_INIT, DP_GCD_STEP, DP_GCD_UPD,
      DP_RED_N, DP_RED_N_UPD, DP_RED_D, DP_RED_D_UPD,
      DP_MUL_N, DP_MUL_N_UPD, DP_MUL_D, DP_MUL_D_UPD,
      DP_DIV_Q, DP_DIV_Q_UPD, DP_INC_Q,
      DP_DIV_PER, DP_DIV_PER_UPD, DP_PER_ONE,
      DP_MUL_T, DP_MUL_T_UPD, DP_FINISH
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_GCD_INIT, S_GCD_TEST, S_GCD_WAIT,
      S_RED_N_WAIT, S_RED_D, S_RED_D_WAIT, S_MUL_N,
      S_MUL_N_WAIT, S_MUL_D, S_MUL_D_WAIT, S_CHK2, S_DIV_Q_WAIT,
      S_ROUND, S_PER, S_PER_WAIT, S_PER_CHK, S_MUL_T, S_MUL_T_WAIT, S_FIN
   } state_type;

   typedef struct packed {
      logic [63:0] magnitude;
      logic [63:0] divisor;
      logic [3:0]  unit_code;
      logic        has_precision;
      logic [63:0] precision_fs;
   } req_type;

   typedef struct packed {
      logic [63:0] ticks;
      logic [3:0]  status;
   } rsp_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] pair;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic code_zero;
      logic div_one;
      logic bad;
      logic gb_zero;
      logic seq_done;
      logic num_ovf;
      logic den_ovf;
      logic den_zero;
      logic prec;
      logic round_up;
      logic q_at_lim;
      logic r_nonzero;
      logic tick_zero;
      logic per_rem_nz;
      logic prod_ovf;
   } dp_stat_type;

   function automatic logic [63:0] unit_scale(input logic [3:0] code);
      case (code)
         4'd1:    unit_scale = 64'd1;
         4'd2:    unit_scale = 64'd1000;
         4'd3:    unit_scale = 64'd1000000;
         4'd4:    unit_scale = 64'd1000000000;
         4'd5:    unit_scale = 64'd1000000000000;
         4'd6:    unit_scale = 64'd1000000000000000;
         4'd7:    unit_scale = 64'd60000000000000000;
         4'd8:    unit_scale = 64'd3600000000000000000;
         default: unit_scale = 64'd0;
      endcase
   endfunction

endpackage

@@ hdl/delay_to_tick_normalizer_unit.sv @@
// -----------------------------------------------------------------------------
// delay_to_tick_normalizer_unit
// Converts a delay (magnitude, divisor, unit) into simulation ticks.
// -----------------------------------------------------------------------------
// channel   ports                       handshake
// request   start, busy, req            beat taken when start & !busy
// response  rsp_strobe, rsp             one-cycle strobe, no back-pressure
// config    csr_valid, csr_ready, csr_data  beat taken when valid & ready
//
// One item at a time; each serial divide/multiply holds the shared unit from its
// issue to its collect. Unitless or invalid items finish in the check cycle and
// strobe in the cycle after. A full conversion runs 12 serial operations
// (13 with a precision) plus one per Euclid step of the four gcds.
// Reset is synchronous and restores the tick length to 1 ns (1000000 fs).
// The result strobe cannot be held off; csr_ready is low while busy.
// -----------------------------------------------------------------------------
module delay_to_tick_normalizer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dtn_pkg::req_type req,
   output logic             rsp_strobe,
   output dtn_pkg::rsp_type rsp,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [63:0]      csr_data
);
   import dtn_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        busy_w;

   dtn_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy_w),
      .cmd   (cmd)
   );

   dtn_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req),
      .csr_we     (csr_valid && !busy_w),
      .csr_data   (csr_data),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   assign busy      = busy_w;
   assign csr_ready = !busy_w;

endmodule

@@ hdl/dtn_seq_unit.sv @@
// -----------------------------------------------------------------------------
// dtn_seq_unit
// Shared serial unit: 64-bit restoring divide or shift-add multiply, one bit
// per cycle.
// -----------------------------------------------------------------------------
module dtn_seq_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_mul,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] quot,
   output logic [63:0] rem,
   output logic        ovf
);
   import dtn_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic              mul_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WORD_W:0]   hi_ff;
   logic [WORD_W-1:0] lo_ff;
   logic [WORD_W-1:0] b_ff;

   logic [WORD_W:0]   trial;
   logic              fits;
   logic [WORD_W:0]   sum;

   always_comb begin
      trial = {hi_ff[WORD_W-1:0], lo_ff[WORD_W-1]};
      fits  = trial >= {1'b0, b_ff};
      sum   = {1'b0, hi_ff[WORD_W-1:0]} + {1'b0, b_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WORD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mul_ff <= is_mul;
         hi_ff  <= '0;
         lo_ff  <= op_a;
         b_ff   <= op_b;
      end else if (busy_ff) begin
         if (mul_ff) begin
            // add when the low multiplier bit is set, then shift the pair right
            if (lo_ff[0]) begin
               hi_ff <= {1'b0, sum[WORD_W:1]};
               lo_ff <= {sum[0], lo_ff[WORD_W-1:1]};
            end else begin
               hi_ff <= {1'b0, 1'b0, hi_ff[WORD_W-1:1]};
               lo_ff <= {hi_ff[0], lo_ff[WORD_W-1:1]};
            end
         end else begin
            hi_ff <= fits ? (trial - {1'b0, b_ff}) : trial;
            lo_ff <= {lo_ff[WORD_W-2:0], fits};
         end
      end
   end

   assign done = done_ff;
   assign quot = lo_ff;
   assign rem  = hi_ff[WORD_W-1:0];
   assign ovf  = (hi_ff[WORD_W-1:0] != '0) || ((lo_ff & ~TIME_LIMIT) != '0);

endmodule

@@ hdl/dtn_datapath.sv @@
// -----------------------------------------------------------------------------
// dtn_datapath
// Operand registers, tick register, serial unit and result register.
// -----------------------------------------------------------------------------
module dtn_datapath (
   input  logic                clock,
   input  logic                reset,
   input  dtn_pkg::dp_cmd_type cmd,
   input  dtn_pkg::req_type    req,
   input  logic                csr_we,
   input  logic [63:0]         csr_data,
   output dtn_pkg::dp_stat_type stat,
   output logic                rsp_strobe,
   output dtn_pkg::rsp_type    rsp
);
   import dtn_pkg::*;

   logic [63:0] tick_ff, mag_ff, quantum_ff;
   logic [3:0]  code_ff;
   logic        prec_ff;
   logic [63:0] n0_ff, n1_ff, d0_ff, d1_ff, ga_ff, gb_ff;
   logic [63:0] num_ff, den_ff, q_ff, r_ff, per_ff, prod_ff;
   logic        num_ovf_ff, den_ovf_ff, prod_ovf_ff, per_rem_ff;
   logic        strobe_ff;
   rsp_type     rsp_ff;

   logic        seq_start, seq_mul, seq_done, seq_ovf;
   logic [63:0] seq_a, seq_b, seq_quot, seq_rem, gval, half;

   assign gval = (ga_ff == '0) ? 64'd1 : ga_ff;
   assign half = (den_ff >> 1) + {63'd0, den_ff[0]};

   always_comb begin
      seq_start = 1'b1;
      seq_mul   = 1'b0;
      seq_a     = ga_ff;
      seq_b     = gb_ff;
      case (cmd.op)
         DP_GCD_STEP: ;
         DP_RED_N: begin
            seq_a = cmd.pair[1] ? n1_ff : n0_ff;
            seq_b = gval;
         end
         DP_RED_D: begin
            seq_a = cmd.pair[0] ? d1_ff : d0_ff;
            seq_b = gval;
         end
         DP_MUL_N: begin
            seq_mul = 1'b1;
            seq_a   = n0_ff;
            seq_b   = n1_ff;
         end
         DP_MUL_D: begin
            seq_mul = 1'b1;
            seq_a   = d0_ff;
            seq_b   = d1_ff;
         end
         DP_DIV_Q: begin
            seq_a = num_ff;
            seq_b = den_ff;
         end
         DP_DIV_PER: begin
            seq_a = quantum_ff;
            seq_b = tick_ff;
         end
         DP_MUL_T: begin
            seq_mul = 1'b1;
            seq_a   = q_ff;
            seq_b   = per_ff;
         end
         default: seq_start = 1'b0;
      endcase
   end

   dtn_seq_unit u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (seq_start),
      .is_mul (seq_mul),
      .op_a   (seq_a),
      .op_b   (seq_b),
      .done   (seq_done),
      .quot   (seq_quot),
      .rem    (seq_rem),
      .ovf    (seq_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= TICK_RESET;
      end else if (csr_we) begin
         tick_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd.op == DP_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            mag_ff     <= req.magnitude;
            code_ff    <= req.unit_code;
            prec_ff    <= req.has_precision;
            quantum_ff <= req.has_precision ? req.precision_fs : tick_ff;
            n0_ff      <= req.magnitude;
            n1_ff      <= unit_scale(req.unit_code);
            d0_ff      <= req.divisor;
            d1_ff      <= req.has_precision ? req.precision_fs : tick_ff;
         end
         DP_GCD_INIT: begin
            ga_ff <= cmd.pair[1] ? n1_ff : n0_ff;
            gb_ff <= cmd.pair[0] ? d1_ff : d0_ff;
         end
         DP_GCD_UPD: begin
            ga_ff <= gb_ff;
            gb_ff <= seq_rem;
         end
         DP_RED_N_UPD: begin
            if (cmd.pair[1]) n1_ff <= seq_quot;
            else             n0_ff <= seq_quot;
         end
         DP_RED_D_UPD: begin
            if (cmd.pair[0]) d1_ff <= seq_quot;
            else             d0_ff <= seq_quot;
         end
         DP_MUL_N_UPD: begin
            num_ff     <= seq_quot;
            num_ovf_ff <= seq_ovf;
         end
         DP_MUL_D_UPD: begin
            den_ff     <= seq_quot;
            den_ovf_ff <= seq_ovf;
         end
         DP_DIV_Q_UPD: begin
            q_ff <= seq_quot;
            r_ff <= seq_rem;
         end
         DP_INC_Q: q_ff <= q_ff + 64'd1;
         DP_DIV_PER_UPD: begin
            per_ff     <= seq_quot;
            per_rem_ff <= (seq_rem != '0);
         end
         DP_PER_ONE: per_ff <= 64'd1;
         DP_MUL_T_UPD: begin
            prod_ff     <= seq_quot;
            prod_ovf_ff <= seq_ovf;
         end
         DP_FINISH: begin
            rsp_ff.status <= cmd.status;
            if (cmd.status != ST_OK) rsp_ff.ticks <= '0;
            else if (code_ff == UNIT_NONE) rsp_ff.ticks <= mag_ff;
            else rsp_ff.ticks <= prod_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.code_zero  = (code_ff == UNIT_NONE);
      stat.div_one    = (d0_ff == 64'd1);
      stat.bad        = (code_ff > UNIT_HR) || (d0_ff == '0);
      stat.gb_zero    = (gb_ff == '0);
      stat.seq_done   = seq_done;
      stat.num_ovf    = num_ovf_ff;
      stat.den_ovf    = den_ovf_ff;
      stat.den_zero   = (den_ff == '0);
      stat.prec       = prec_ff;
      stat.round_up   = (r_ff >= half);
      stat.q_at_lim   = (q_ff >= TIME_LIMIT);
      stat.r_nonzero  = (r_ff != '0);
      stat.tick_zero  = (tick_ff == '0);
      stat.per_rem_nz = per_rem_ff;
      stat.prod_ovf   = prod_ovf_ff;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

@@ hdl/dtn_ctrl.sv @@
// -----------------------------------------------------------------------------
// dtn_ctrl
// Sequencer: gcd reductions, products, quotient, rounding and tick scaling.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  dtn_pkg::dp_stat_type stat,
   output logic                 busy,
   output dtn_pkg::dp_cmd_type  cmd
);
   import dtn_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] pair_ff, pair_in;
   logic       in_wait;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pair_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pair_ff  <= pair_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pair_in  = pair_ff;
      case (state_ff)
         S_IDLE:       if (start) state_in = S_CHECK;
         S_CHECK: begin
            pair_in = '0;
            if (stat.code_zero || stat.bad) state_in = S_IDLE;
            else                            state_in = S_GCD_INIT;
         end
         S_GCD_INIT:   state_in = S_GCD_TEST;
         S_GCD_TEST:   state_in = stat.gb_zero ? S_RED_N_WAIT : S_GCD_WAIT;
         S_GCD_WAIT:   if (stat.seq_done) state_in = S_GCD_TEST;
         S_RED_N_WAIT: if (stat.seq_done) state_in = S_RED_D;
         S_RED_D:      state_in = S_RED_D_WAIT;
         S_RED_D_WAIT: begin
            if (stat.seq_done) begin
               pair_in  = pair_ff + 2'd1;
               state_in = (pair_ff == 2'd3) ? S_MUL_N : S_GCD_INIT;
            end
         end
         S_MUL_N:      state_in = S_MUL_N_WAIT;
         S_MUL_N_WAIT: if (stat.seq_done) state_in = S_MUL_D;
         S_MUL_D:      state_in = S_MUL_D_WAIT;
         S_MUL_D_WAIT: if (stat.seq_done) state_in = S_CHK2;
         S_CHK2: begin
            if (stat.num_ovf || stat.den_ovf || stat.den_zero) state_in = S_IDLE;
            else                                               state_in = S_DIV_Q_WAIT;
         end
         S_DIV_Q_WAIT: if (stat.seq_done) state_in = S_ROUND;
         S_ROUND: begin
            if (stat.prec && stat.round_up && stat.q_at_lim)  state_in = S_IDLE;
            else if (!stat.prec && stat.r_nonzero)            state_in = S_IDLE;
            else                                              state_in = S_PER;
         end
         S_PER: begin
            if (!stat.prec)          state_in = S_MUL_T;
            else if (stat.tick_zero) state_in = S_IDLE;
            else                     state_in = S_PER_WAIT;
         end
         S_PER_WAIT:   if (stat.seq_done) state_in = S_PER_CHK;
         S_PER_CHK:    state_in = stat.per_rem_nz ? S_IDLE : S_MUL_T;
         S_MUL_T:      state_in = S_MUL_T_WAIT;
         S_MUL_T_WAIT: if (stat.seq_done) state_in = S_FIN;
         S_FIN:        state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = DP_NOP;
      cmd.pair   = pair_ff;
      cmd.status = ST_OK;
      case (state_ff)
         S_IDLE:       if (start) cmd.op = DP_LOAD;
         S_CHECK: begin
            if (stat.code_zero) begin
               cmd.op     = DP_FINISH;
               cmd.status = stat.div_one ? ST_OK : ST_UNITLESS_FRAC;
            end else if (stat.bad) begin
               cmd.op     = DP_FINISH;
               cmd.status = ST_INVALID;
            end
         end
         S_GCD_INIT:   cmd.op = DP_GCD_INIT;
         S_GCD_TEST:   cmd.op = stat.gb_zero ? DP_RED_N : DP_GCD_STEP;
         S_GCD_WAIT:   if (stat.seq_done) cmd.op = DP_GCD_UPD;
         S_RED_N_WAIT: if (stat.seq_done) cmd.op = DP_RED_N_UPD;
         S_RED_D:      cmd.op = DP_RED_D;
         S_RED_D_WAIT: begin
            if (stat.seq_done) cmd.op = DP_RED_D_UPD;
         end
         S_MUL_N:      cmd.op = DP_MUL_N;
         S_MUL_N_WAIT: if (stat.seq_done) cmd.op = DP_MUL_N_UPD;
         S_MUL_D:      cmd.op = DP_MUL_D;
         S_MUL_D_WAIT: if (stat.seq_done) cmd.op = DP_MUL_D_UPD;
         S_CHK2: begin
            cmd.op = DP_FINISH;
            if (stat.num_ovf)       cmd.status = ST_TIME_OVF;
            else if (stat.den_ovf)  cmd.status = ST_PREC_RANGE;
            else if (stat.den_zero) cmd.status = ST_ZERO_DEN;
            else                    cmd.op     = DP_DIV_Q;
         end
         S_DIV_Q_WAIT: if (stat.seq_done) cmd.op = DP_DIV_Q_UPD;
         S_ROUND: begin
            if (stat.prec && stat.round_up) begin
               if (stat.q_at_lim) begin
                  cmd.op     = DP_FINISH;
                  cmd.status = ST_ROUND_OVF;
               end else begin
                  cmd.op = DP_INC_Q;
               end
            end else if (!stat.prec && stat.r_nonzero) begin
               cmd.op     = DP_FINISH;
               cmd.status = ST_INEXACT;
            end
         end
         S_PER: begin
            if (!stat.prec) begin
               cmd.op = DP_PER_ONE;
            end else if (stat.tick_zero) begin
               cmd.op     = DP_FINISH;
               cmd.status = ST_PREC_NOT_MULT;
            end else begin
               cmd.op = DP_DIV_PER;
            end
         end
         S_PER_WAIT:   if (stat.seq_done) cmd.op = DP_DIV_PER_UPD;
         S_PER_CHK: begin
            if (stat.per_rem_nz) begin
               cmd.op     = DP_FINISH;
               cmd.status = ST_PREC_NOT_MULT;
            end
         end
         S_MUL_T:      cmd.op = DP_MUL_T;
         S_MUL_T_WAIT: if (stat.seq_done) cmd.op = DP_MUL_T_UPD;
         S_FIN: begin
            cmd.op     = DP_FINISH;
            cmd.status = stat.prod_ovf ? ST_TICK_OVF : ST_OK;
         end
         default: ;
      endcase
   end

   assign in_wait = state_ff inside {S_GCD_WAIT, S_RED_N_WAIT, S_RED_D_WAIT, S_MUL_N_WAIT,
                                     S_MUL_D_WAIT, S_DIV_Q_WAIT, S_PER_WAIT, S_MUL_T_WAIT};

   assign busy = (state_ff != S_IDLE);

   `DTN_ASSERT(a_finish_to_idle, (cmd.op == DP_FINISH) |=> (state_ff == S_IDLE), "no idle after finish")
   `DTN_ASSERT(a_accept_leaves_idle, (start && !busy) |=> (state_ff == S_CHECK), "accepted item not checked")
   `DTN_ASSERT_ALWAYS(a_done_in_wait, (stat.seq_done && !reset) |-> in_wait, "serial done outside wait")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Drives delays through the tick normalizer and checks every result against
// an in-bench conversion model, across several tick lengths.
// -----------------------------------------------------------------------------

class tick_scoreboard;
   logic [63:0] tick_fs;
   dtn_pkg::rsp_type pending[$];
   int errors;
   int checked;

   function new();
      tick_fs = dtn_pkg::TICK_RESET;
      errors = 0;
      checked = 0;
   endfunction

   function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic void shrink(ref logic [63:0] n, ref logic [63:0] d);
      logic [63:0] g;
      g = euclid(n, d);
      if (g == 0) g = 1;
      n = n / g;
      d = d / g;
   endfunction

   function automatic dtn_pkg::rsp_type convert(dtn_pkg::req_type r);
      dtn_pkg::rsp_type o;
      logic [63:0] lim, quantum, n0, n1, d0, d1, num, den, q, rem, half, per, scale;
      lim = dtn_pkg::TIME_LIMIT;
      o.ticks = 0;
      case (r.unit_code)
         4'd1: scale = 64'd1;
         4'd2: scale = 64'd1000;
         4'd3: scale = 64'd1000000;
         4'd4: scale = 64'd1000000000;
         4'd5: scale = 64'd1000000000000;
         4'd6: scale = 64'd1000000000000000;
         4'd7: scale = 64'd60000000000000000;
         4'd8: scale = 64'd3600000000000000000;
         default: scale = 0;
      endcase
      if (r.unit_code == dtn_pkg::UNIT_NONE) begin
         if (r.divisor != 1) o.status = dtn_pkg::ST_UNITLESS_FRAC;
         else begin
            o.ticks = r.magnitude;
            o.status = dtn_pkg::ST_OK;
         end
         return o;
      end
      if (r.unit_code > dtn_pkg::UNIT_HR || r.divisor == 0) begin
         o.status = dtn_pkg::ST_INVALID;
         return o;
      end
      quantum = r.has_precision ? r.precision_fs : tick_fs;
      n0 = r.magnitude; n1 = scale; d0 = r.divisor; d1 = quantum;
      shrink(n0, d0);
      shrink(n0, d1);
      shrink(n1, d0);
      shrink(n1, d1);
      if (n0 != 0 && n1 > lim / n0) begin
         o.status = dtn_pkg::ST_TIME_OVF;
         return o;
      end
      if (d0 != 0 && d1 > lim / d0) begin
         o.status = dtn_pkg::ST_PREC_RANGE;
         return o;
      end
      num = n0 * n1;
      den = d0 * d1;
      if (den == 0) begin
         o.status = dtn_pkg::ST_ZERO_DEN;
         return o;
      end
      q = num / den;
      rem = num % den;
      if (r.has_precision) begin
         half = den / 2 + (den & 1);
         if (rem >= half) begin
            if (q >= lim) begin
               o.status = dtn_pkg::ST_ROUND_OVF;
               return o;
            end
            q++;
         end
      end else if (rem != 0) begin
         o.status = dtn_pkg::ST_INEXACT;
         return o;
      end
      per = 1;
      if (r.has_precision) begin
         if (tick_fs == 0 || quantum % tick_fs != 0) begin
            o.status = dtn_pkg::ST_PREC_NOT_MULT;
            return o;
         end
         per = quantum / tick_fs;
      end
      if (q != 0 && per > lim / q) begin
         o.status = dtn_pkg::ST_TICK_OVF;
         return o;
      end
      o.ticks = q * per;
      o.status = dtn_pkg::ST_OK;
      return o;
   endfunction

   function void note_request(dtn_pkg::req_type r);
      pending = {pending, convert(r)};
   endfunction

   function void check_result(dtn_pkg::rsp_type got);
      dtn_pkg::rsp_type want;
      checked++;
      if (pending.size() == 0) begin
         $error("unexpected result ticks=%0d status=%0d", got.ticks, got.status);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.ticks !== want.ticks) begin
         $error("ticks: expected %0d, actual %0d", want.ticks, got.ticks);
         errors++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         errors++;
      end
   endfunction
endclass

module tb;
   import dtn_pkg::*;

   localparam int WATCHDOG = 100000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req = '0;
   logic rsp_strobe;
   rsp_type rsp;
   logic csr_valid = 0;
   logic csr_ready;
   logic [63:0] csr_data = '0;

   tick_scoreboard board;
   int idle_cycles;
   int sent;
   bit timed_out;

   delay_to_tick_normalizer_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_strobe(rsp_strobe), .rsp(rsp), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   initial board = new();

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_result(rsp);
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end else idle_cycles <= 0;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_delay(req_type r);
      int gap;
      gap = $urandom_range(0, 8);
      // step off the falling edge that dropped start for the last beat
      @(negedge clock);
      repeat (gap) @(negedge clock);
      req <= r;
      start <= 1;
      do @(posedge clock); while (busy);
      board.note_request(r);
      sent++;
      @(negedge clock);
      start <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      // an invalid or unitless item may still be finishing
      repeat (8) @(negedge clock);
   endtask

   task automatic write_tick(logic [63:0] v);
      drain();
      csr_data <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      board.tick_fs = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic req_type make_req(logic [63:0] m, logic [63:0] d, logic [3:0] u,
                                        logic p, logic [63:0] pf);
      req_type r;
      r.magnitude = m; r.divisor = d; r.unit_code = u;
      r.has_precision = p; r.precision_fs = pf;
      return r;
   endfunction

   function automatic logic [63:0] pick_word();
      logic [63:0] pow;
      case ($urandom_range(0, 5))
         0: return rand64();
         1: return rand64() >> $urandom_range(0, 63);
         2: return 64'($urandom_range(0, 20));
         3: begin
            pow = 1;
            repeat ($urandom_range(0, 19)) pow = pow * 10;
            return pow * $urandom_range(1, 9);
         end
         4: return {64{1'b1}} - $urandom_range(0, 3);
         default: return 64'($urandom_range(1, 100000));
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      logic [63:0] t;
      r.magnitude = pick_word();
      r.divisor = ($urandom_range(0, 3) == 0) ? pick_word() : 64'($urandom_range(1, 4));
      r.unit_code = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 8));
      r.has_precision = 1'($urandom_range(0, 1));
      // favor precisions that are tick multiples so rounding goes all the way
      t = board.tick_fs;
      if ($urandom_range(0, 2) != 0 && t != 0) r.precision_fs = t * $urandom_range(1, 1000);
      else r.precision_fs = pick_word();
      return r;
   endfunction

   task automatic random_phase(int count);
      repeat (count) send_delay(random_req());
   endtask

   initial begin
      logic [63:0] ones;
      ones = {64{1'b1}};
      sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed beats
      send_delay(make_req(64'd5, 64'd1, UNIT_NONE, 0, 0));
      send_delay(make_req(ones, 64'd1, UNIT_NONE, 1, ones));
      send_delay(make_req(64'd5, 64'd2, UNIT_NONE, 0, 0));
      send_delay(make_req(64'd5, 64'd1, 4'd9, 0, 0));
      send_delay(make_req(64'd5, 64'd1, 4'd15, 0, 0));
      send_delay(make_req(64'd5, 64'd0, 4'd3, 0, 0));
      send_delay(make_req(64'd1, 64'd1, 4'd1, 0, 0));
      send_delay(make_req(64'd1000000, 64'd1, 4'd1, 0, 0));
      send_delay(make_req(64'd3, 64'd1, 4'd2, 0, 0));
      send_delay(make_req(64'd7, 64'd2, 4'd3, 0, 0));
      send_delay(make_req(64'd250, 64'd1, 4'd4, 0, 0));
      send_delay(make_req(64'd2, 64'd1, 4'd5, 0, 0));
      send_delay(make_req(ones, 64'd1, 4'd6, 0, 0));
      send_delay(make_req(64'd3, 64'd1, 4'd7, 0, 0));
      send_delay(make_req(64'd5, 64'd1, UNIT_HR, 0, 0));
      send_delay(make_req(64'd0, 64'd7, 4'd3, 0, 0));
      send_delay(make_req(64'd15, 64'd10, 4'd3, 1, 64'd1000000));
      send_delay(make_req(64'd14, 64'd10, 4'd3, 1, 64'd1000000));
      send_delay(make_req(64'd5, 64'd1, 4'd3, 1, 64'd0));
      send_delay(make_req(64'd5, 64'd1, 4'd3, 1, 64'd1500000));
      send_delay(make_req(64'd1, 64'd3, 4'd3, 1, ones));
      send_delay(make_req(ones, 64'd1, 4'd1, 1, 64'd2));
      send_delay(make_req(64'd1, ones, 4'd2, 1, ones));
      send_delay(make_req(ones, 64'd1, UNIT_HR, 1, 64'd1000000000));

      random_phase(150);
      // hold off until the block has delivered everything
      drain();
      write_tick(64'd1);
      send_delay(make_req(ones, 64'd1, 4'd1, 1, 64'd3));
      random_phase(100);
      write_tick(0);
      send_delay(make_req(64'd0, 64'd1, 4'd3, 0, 0));
      send_delay(make_req(64'd5, 64'd1, 4'd3, 1, 64'd1000));
      random_phase(40);
      write_tick(ones);
      random_phase(60);
      write_tick(64'd1000);
      random_phase(120);
      write_tick(rand64());
      random_phase(40);
      write_tick(TICK_RESET);
      random_phase(30);

      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Sent %0d delays over six tick lengths, %0d results checked.",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/dtn_pkg.sv
hdl/dtn_seq_unit.sv
hdl/dtn_datapath.sv
hdl/dtn_ctrl.sv
hdl/delay_to_tick_normalizer_unit.sv
verif/tb.sv
